// ===== rtl/core/cpd_pkg.sv =====
`timescale 1ns / 1ps

package cpd_pkg;

  // default values for the top level parameters
  localparam int DEF_SAMPLE_BITS       = 16;
  localparam int DEF_MAX_CHANNELS      = 8;
  localparam int DEF_MAX_WINDOW_FRAMES = 19200;

  // fixed accumulator and field widths
  localparam int WE_W    = 48;  // window energy
  localparam int TE_W    = 64;  // cumulative energy
  localparam int TS_W    = 40;  // cumulative sample count
  localparam int FRAME_W = 32;  // frame positions
  localparam int XF_W    = 33;  // signed crossfade frame
  localparam int DIGIT_W = 8;   // multiplier digit per step
  localparam int Q_SHIFT = 16;  // fraction bits of the ratio

  // configuration register widths
  localparam int CH_CFG_W   = 4;
  localparam int WIN_CFG_W  = 15;
  localparam int RATIO_W    = 16;
  localparam int SEEK_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // configuration reset values
  localparam logic [CH_CFG_W-1:0]  CH_RST    = 4'd2;
  localparam logic [WIN_CFG_W-1:0] WIN_RST   = 15'd4800;
  localparam logic [RATIO_W-1:0]   RATIO_RST = 16'd5898;
  localparam logic [SEEK_W-1:0]    SEEK_RST  = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_WINDOW_FRAMES = 2'd1,
    CFG_RATIO_SQUARED = 2'd2,
    CFG_SEEK_OFFSET   = 2'd3
  } cfg_idx_t;

  // multiplier operand selection
  localparam logic MUL_SEL_L = 1'b0;  // window energy times sample count
  localparam logic MUL_SEL_R = 1'b1;  // ratio count product times total energy

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_CHECK,
    ST_NW,
    ST_MUL_L,
    ST_MUL_R,
    ST_CMP,
    ST_EMIT
  } cpd_state_t;

  typedef struct packed {
    logic in_ready;
    logic square;
    logic accum;
    logic calc_nw;
    logic ld_k;
    logic mul_start;
    logic mul_sel;
    logic lat_l;
    logic cmp;
    logic emit;
  } cpd_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic close_due;
    logic last;
    logic mul_done;
    logic out_free;
  } cpd_status_t;

endpackage

// ===== rtl/core/cpd_in_if.sv =====
`timescale 1ns / 1ps

interface cpd_in_if #(
  parameter int SAMPLE_BITS = cpd_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== rtl/core/cpd_out_if.sv =====
`timescale 1ns / 1ps

interface cpd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cpd_pkg::XF_W-1:0]  crossfade_frame;
  logic [cpd_pkg::FRAME_W-1:0]      track_frames;

  modport source (output valid, output crossfade_frame, output track_frames, input ready);
  modport sink   (input valid, input crossfade_frame, input track_frames, output ready);
endinterface

// ===== rtl/core/cpd_mul.sv =====
`timescale 1ns / 1ps

module cpd_mul #(
  parameter int A_W = cpd_pkg::TE_W,
  parameter int B_W = cpd_pkg::TS_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+cpd_pkg::DIGIT_W*((B_W+cpd_pkg::DIGIT_W-1)/cpd_pkg::DIGIT_W)-1:0] acc,
  output logic                 done
);
  localparam int DW     = cpd_pkg::DIGIT_W;
  localparam int DIGITS = (B_W + DW - 1) / DW;
  localparam int BP_W   = DIGITS * DW;
  localparam int ACC_W  = A_W + BP_W;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int P_W    = A_W + DW;

  logic [A_W-1:0]   a_r;
  logic [BP_W-1:0]  b_r;
  logic [ACC_W-1:0] acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W-1:0]   prod;

  // one digit of b per step, most significant first
  assign prod = P_W'(a_r) * P_W'(b_r[BP_W-1 -: DW]);

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIGITS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // operands and shift-add accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= BP_W'(b);
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      b_r   <= b_r << DW;
      acc_r <= (acc_r << DW) + ACC_W'(prod);
    end
  end

  assign acc  = acc_r;
  assign done = (cnt_r == '0);
endmodule

// ===== rtl/core/cpd_ctrl.sv =====
`timescale 1ns / 1ps

module cpd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpd_pkg::cpd_status_t status,
  output cpd_pkg::cpd_cmd_t    cmd
);
  cpd_pkg::cpd_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = cpd_pkg::MUL_SEL_L;
    unique case (state_r)
      cpd_pkg::ST_IDLE: begin
        // no beat is taken while reset is held
        cmd.in_ready = rst_n;
        if (status.in_valid) begin
          state_nxt = cpd_pkg::ST_SQUARE;
        end
      end
      cpd_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = cpd_pkg::ST_ACCUM;
      end
      cpd_pkg::ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = cpd_pkg::ST_CHECK;
      end
      cpd_pkg::ST_CHECK: begin
        if (status.close_due) begin
          state_nxt = cpd_pkg::ST_NW;
        end else begin
          state_nxt = cpd_pkg::ST_IDLE;
        end
      end
      cpd_pkg::ST_NW: begin
        cmd.calc_nw   = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = cpd_pkg::MUL_SEL_L;
        state_nxt     = cpd_pkg::ST_MUL_L;
      end
      cpd_pkg::ST_MUL_L: begin
        cmd.ld_k = 1'b1;
        if (status.mul_done) begin
          cmd.lat_l     = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = cpd_pkg::MUL_SEL_R;
          state_nxt     = cpd_pkg::ST_MUL_R;
        end
      end
      cpd_pkg::ST_MUL_R: begin
        if (status.mul_done) begin
          state_nxt = cpd_pkg::ST_CMP;
        end
      end
      cpd_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
        if (status.last) begin
          state_nxt = cpd_pkg::ST_EMIT;
        end else begin
          state_nxt = cpd_pkg::ST_IDLE;
        end
      end
      cpd_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = cpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cpd_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

// ===== rtl/core/cpd_datapath.sv =====
`timescale 1ns / 1ps

module cpd_datapath #(
  parameter int SAMPLE_BITS       = cpd_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_CHANNELS      = cpd_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_WINDOW_FRAMES = cpd_pkg::DEF_MAX_WINDOW_FRAMES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  cpd_in_if.sink                            in_ch,
  cpd_out_if.source                         out_ch,
  input  cpd_pkg::cpd_cmd_t                 cmd,
  output cpd_pkg::cpd_status_t              status
);
  localparam int SB      = SAMPLE_BITS;
  localparam int SQ_W    = 2 * SB;
  localparam int WE_W    = cpd_pkg::WE_W;
  localparam int TE_W    = cpd_pkg::TE_W;
  localparam int TS_W    = cpd_pkg::TS_W;
  localparam int FRAME_W = cpd_pkg::FRAME_W;
  localparam int XF_W    = cpd_pkg::XF_W;
  localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
  localparam int CP_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CC_W    = CH_W + CP_W;
  localparam int FIW_W   = $clog2(MAX_WINDOW_FRAMES + 1);
  localparam int NW_W    = FIW_W + CH_W;
  localparam int K_W     = cpd_pkg::RATIO_W + NW_W;
  localparam int MB_W    = (K_W > TS_W) ? K_W : TS_W;
  localparam int DW      = cpd_pkg::DIGIT_W;
  localparam int ACC_W   = TE_W + DW * ((MB_W + DW - 1) / DW);
  localparam int L_W     = WE_W + TS_W;
  localparam int QS      = cpd_pkg::Q_SHIFT;

  // configuration registers
  logic [cpd_pkg::CH_CFG_W-1:0]  ch_cfg_r;
  logic [cpd_pkg::WIN_CFG_W-1:0] win_cfg_r;
  logic [cpd_pkg::RATIO_W-1:0]   ratio_r;
  logic [cpd_pkg::SEEK_W-1:0]    seek_r;

  // track state
  logic [WE_W-1:0]    we_r;
  logic [TE_W-1:0]    te_r;
  logic [TS_W-1:0]    ts_r;
  logic [FIW_W-1:0]   fiw_r;
  logic [CP_W-1:0]    cp_r;
  logic [FRAME_W-1:0] fd_r;
  logic [FRAME_W-1:0] best_r;

  // per beat and window close working registers
  logic [SB-1:0]      sample_r;
  logic               last_r;
  logic               close_due_r;
  logic [SQ_W-1:0]    sq_r;
  logic [NW_W-1:0]    nw_r;
  logic [FRAME_W-1:0] pos_r;
  logic [K_W-1:0]     k_r;
  logic [L_W-1:0]     l_r;

  // result register
  logic               out_valid_r;
  logic [XF_W-1:0]    xf_r;
  logic [FRAME_W-1:0] track_r;

  logic               in_acc;
  logic               out_free;
  logic [CH_W-1:0]    ch_eff;
  logic [FIW_W-1:0]   win_eff;
  logic [SB-1:0]      mag;
  logic [WE_W:0]      we_sum;
  logic [TE_W:0]      te_sum;
  logic [CC_W-1:0]    cp_inc;
  logic               wrap;
  logic [FIW_W-1:0]   fiw_inc;
  logic [FRAME_W:0]   pos_sum;
  logic [TE_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [ACC_W-1:0]   mul_acc;
  logic               mul_done;
  logic [ACC_W-1:0]   lhs;
  logic               record;

  assign in_acc   = in_ch.valid && cmd.in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // effective channel count and window length
  always_comb begin
    priority if (ch_cfg_r == '0) begin
      ch_eff = CH_W'(1);
    end else if (ch_cfg_r > MAX_CHANNELS) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = CH_W'(ch_cfg_r);
    end
  end

  always_comb begin
    priority if (win_cfg_r == '0) begin
      win_eff = FIW_W'(1);
    end else if (win_cfg_r > MAX_WINDOW_FRAMES) begin
      win_eff = FIW_W'(MAX_WINDOW_FRAMES);
    end else begin
      win_eff = FIW_W'(win_cfg_r);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cfg_r  <= cpd_pkg::CH_RST;
      win_cfg_r <= cpd_pkg::WIN_RST;
      ratio_r   <= cpd_pkg::RATIO_RST;
      seek_r    <= cpd_pkg::SEEK_RST;
    end else if (cfg_we) begin
      unique case (cpd_pkg::cfg_idx_t'(cfg_index))
        cpd_pkg::CFG_CHANNEL_COUNT: ch_cfg_r  <= cfg_data[cpd_pkg::CH_CFG_W-1:0];
        cpd_pkg::CFG_WINDOW_FRAMES: win_cfg_r <= cfg_data[cpd_pkg::WIN_CFG_W-1:0];
        cpd_pkg::CFG_RATIO_SQUARED: ratio_r   <= cfg_data[cpd_pkg::RATIO_W-1:0];
        cpd_pkg::CFG_SEEK_OFFSET:   seek_r    <= cfg_data[cpd_pkg::SEEK_W-1:0];
        default: ;
      endcase
    end
  end

  // sample magnitude; the most negative code maps onto itself as unsigned
  assign mag = sample_r[SB-1] ? (SB'(~sample_r) + SB'(1)) : sample_r;

  // saturating sums and frame step
  assign we_sum  = {1'b0, we_r} + (WE_W + 1)'(sq_r);
  assign te_sum  = {1'b0, te_r} + (TE_W + 1)'(sq_r);
  assign cp_inc  = CC_W'(cp_r) + CC_W'(1);
  assign wrap    = cp_inc >= CC_W'(ch_eff);
  assign fiw_inc = fiw_r + FIW_W'(1);
  assign pos_sum = {1'b0, fd_r} + (FRAME_W + 1)'(fiw_r) + (FRAME_W + 1)'(cp_r != '0);

  // input beat capture and square
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_ch.sample;
    end
    if (cmd.square) begin
      sq_r <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  // close and last flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= 1'b0;
      close_due_r <= 1'b0;
    end else begin
      if (in_acc) begin
        last_r <= in_ch.last_sample;
      end
      if (cmd.accum) begin
        close_due_r <= last_r || (wrap && (fiw_inc >= win_eff));
      end
    end
  end

  // window close arithmetic
  always_ff @(posedge clk) begin
    if (cmd.calc_nw) begin
      nw_r  <= NW_W'(fiw_r) * NW_W'(ch_eff) + NW_W'(cp_r);
      pos_r <= pos_sum[FRAME_W] ? '1 : pos_sum[FRAME_W-1:0];
    end
    if (cmd.ld_k) begin
      k_r <= K_W'(ratio_r) * K_W'(nw_r);
    end
    if (cmd.lat_l) begin
      l_r <= mul_acc[L_W-1:0];
    end
  end

  // shared shift-add multiplier
  assign mul_a = (cmd.mul_sel == cpd_pkg::MUL_SEL_R) ? te_r : TE_W'(we_r);
  assign mul_b = (cmd.mul_sel == cpd_pkg::MUL_SEL_R) ? MB_W'(k_r) : MB_W'(ts_r);

  cpd_mul #(
    .A_W (TE_W),
    .B_W (MB_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .acc   (mul_acc),
    .done  (mul_done)
  );

  // mean square compare without square roots
  assign lhs    = ACC_W'({l_r, QS'(0)});
  assign record = (te_r != '0) && (ts_r != '0) && (lhs > mul_acc);

  // track state update
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      we_r   <= '0;
      te_r   <= '0;
      ts_r   <= '0;
      fiw_r  <= '0;
      cp_r   <= '0;
      fd_r   <= '0;
      best_r <= '0;
    end else if (cmd.accum) begin
      we_r <= we_sum[WE_W] ? '1 : we_sum[WE_W-1:0];
      te_r <= te_sum[TE_W] ? '1 : te_sum[TE_W-1:0];
      if (ts_r != '1) begin
        ts_r <= ts_r + TS_W'(1);
      end
      if (wrap) begin
        cp_r  <= '0;
        fiw_r <= fiw_inc;
      end else begin
        cp_r <= CP_W'(cp_inc);
      end
    end else if (cmd.cmp) begin
      fd_r  <= pos_r;
      if (record) begin
        best_r <= pos_r;
      end
      we_r  <= '0;
      fiw_r <= '0;
      cp_r  <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      xf_r    <= XF_W'({1'b0, best_r}) - XF_W'({1'b0, seek_r});
      track_r <= fd_r;
    end
  end

  assign in_ch.ready            = cmd.in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.crossfade_frame = xf_r;
  assign out_ch.track_frames    = track_r;

  assign status.in_valid  = in_ch.valid;
  assign status.close_due = close_due_r;
  assign status.last      = last_r;
  assign status.mul_done  = mul_done;
  assign status.out_free  = out_free;
endmodule

// ===== rtl/core/crossfade_point_detector.sv =====
`timescale 1ns / 1ps

// Crossfade point detector: squares each interleaved sample beat of a track into a
// window energy and a cumulative energy, and at every window end (and at a final
// partial window) records the frame position when the window mean square exceeds
// ratio_squared (Q0.16) times the cumulative mean square. The beat flagged
// last_sample closes the track and yields one result beat, the recorded frame minus
// seek_offset_frames and the track length in frames, then all track state clears.
// One beat is processed at a time: a beat that closes no window passes from
// acceptance to the next ready through capture, square, accumulate and check. A
// window close adds two products on the shared 64x8 shift-add multiplier, which
// takes one 8-bit digit of its second operand per step, and then a compare.
// The closing beat of a track adds an emit step that waits for the result
// register to drain. No clearing pass follows reset.
module crossfade_point_detector #(
  parameter int SAMPLE_BITS       = cpd_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_CHANNELS      = cpd_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_WINDOW_FRAMES = cpd_pkg::DEF_MAX_WINDOW_FRAMES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpd_pkg::CFG_DATA_W-1:0] cfg_data,
  cpd_in_if.sink                         in_ch,
  cpd_out_if.source                      out_ch
);
  cpd_pkg::cpd_cmd_t    cmd;
  cpd_pkg::cpd_status_t status;

  // sequencer
  cpd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  // accumulators, compare and result register
  cpd_datapath #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .MAX_CHANNELS      (MAX_CHANNELS),
    .MAX_WINDOW_FRAMES (MAX_WINDOW_FRAMES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .status    (status)
  );
endmodule
